@@ hdl/adcsas_pkg.sv @@
// Shared types and constants for the converter scan averager.
// No dependencies; imported by adc_scan_average_scaler_top.
`timescale 1ns / 1ps

package adcsas_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int GAIN_W    = 16;
    localparam int SUM_W     = 18;
    localparam int LEFT_W    = 9;
    localparam int CHAN_W    = 2;
    localparam int MUX_W     = 5;
    localparam int SCALED_W  = 16;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int CFG_IDX_W = 2;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [CHAN_W-1:0] {
        CH_MOTOR_ONE = 2'd0,
        CH_MOTOR_TWO = 2'd1,
        CH_BATTERY   = 2'd2,
        CH_UNUSED    = 2'd3
    } chan_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CURRENT_GAIN = 2'd0,
        REG_BATTERY_GAIN = 2'd1
    } cfg_reg_t;

    localparam logic [MUX_W-1:0] MUX_MOTOR_ONE = 5'b01001;
    localparam logic [MUX_W-1:0] MUX_MOTOR_TWO = 5'b01101;
    localparam logic [MUX_W-1:0] MUX_BATTERY   = 5'b00111;

    localparam logic [GAIN_W-1:0] CURRENT_GAIN_RESET = 16'd942;
    localparam logic [GAIN_W-1:0] BATTERY_GAIN_RESET = 16'd11212;

    localparam logic [SAMPLE_W-1:0] AVG_MAX    = '1;
    localparam logic [SCALED_W-1:0] SCALED_MAX = '1;

endpackage

@@ hdl/adc_scan_average_scaler_top.sv @@
// A channel's result passes through the sample register and then the result register on its way to m_tdata.
// Throughput: one sample per cycle while s_tready is high; a result appears once every SAMPLES samples.
// The sample register and the result register form a two-deep pipeline; stalls on
// m_tready reach s_tready only when both stages are full.
// Reset (rst_n low, async): channel returns to motor one, sum cleared, count reloaded,
// gains back to their defaults, pipeline emptied.
// Depends on adcsas_pkg.
`timescale 1ns / 1ps

module adc_scan_average_scaler_top #(
    parameter int SAMPLES = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // sample request
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [adcsas_pkg::IN_TDATA_W-1:0]     s_tdata,   // [9:0] sample
    // result
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [1:0] channel_done, [11:2] raw_average, [27:12] scaled_value, [32:28] next_mux
    output logic [adcsas_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [adcsas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [adcsas_pkg::GAIN_W-1:0]         cfg_data
);
    import adcsas_pkg::*;

    // floor(log2(SAMPLES))
    localparam int AVG_SHIFT = $clog2(SAMPLES + 1) - 1;
    localparam logic [LEFT_W-1:0] LEFT_RELOAD = LEFT_W'(SAMPLES);

    logic [GAIN_W-1:0]   current_gain_reg;
    logic [GAIN_W-1:0]   battery_gain_reg;

    chan_t               scan_chan_reg,  scan_chan_next;
    logic [LEFT_W-1:0]   left_reg,       left_next;
    logic [SUM_W-1:0]    sum_reg,        sum_next;

    // stage one: averaged channel waiting for its multiply
    logic                avg_valid_reg;
    chan_t               avg_chan_reg;
    logic [SAMPLE_W-1:0] avg_value_reg;
    logic [GAIN_W-1:0]   avg_gain_reg;
    logic [MUX_W-1:0]    avg_mux_reg;

    // stage two: result
    logic                res_valid_reg;
    chan_t               res_chan_reg;
    logic [SAMPLE_W-1:0] res_avg_reg;
    logic [SCALED_W-1:0] res_scaled_reg;
    logic [MUX_W-1:0]    res_mux_reg;

    logic                accept;
    logic                res_free;
    logic                finish;
    chan_t               chan_eff;
    logic [SUM_W-1:0]    sum_total;
    logic [SUM_W-1:0]    sum_shifted;
    logic [SAMPLE_W-1:0] avg_sat;
    logic [GAIN_W-1:0]   gain_sel;
    logic [MUX_W-1:0]    mux_sel;
    logic [PROD_W-1:0]   product;
    logic [SCALED_W-1:0] scaled_sat;

    assign res_free  = !res_valid_reg || m_tready;
    assign s_tready  = !avg_valid_reg || res_free;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign chan_eff    = (scan_chan_reg == CH_UNUSED) ? CH_MOTOR_ONE : scan_chan_reg;
    assign sum_total   = sum_reg + SUM_W'(s_tdata[SAMPLE_W-1:0]);
    assign finish      = (left_reg == LEFT_W'(1));
    assign sum_shifted = sum_total >> AVG_SHIFT;
    assign avg_sat     = (sum_shifted > SUM_W'(AVG_MAX)) ? AVG_MAX
                                                         : sum_shifted[SAMPLE_W-1:0];
    assign gain_sel    = (chan_eff == CH_BATTERY) ? battery_gain_reg : current_gain_reg;

    always_comb
    begin
        scan_chan_next = chan_eff;
        left_next      = left_reg - LEFT_W'(1);
        sum_next       = sum_total;
        mux_sel        = MUX_MOTOR_ONE;
        unique case (chan_eff)
            CH_MOTOR_ONE:
            begin
                mux_sel = MUX_MOTOR_TWO;
                if (finish) scan_chan_next = CH_MOTOR_TWO;
            end
            CH_MOTOR_TWO:
            begin
                mux_sel = MUX_BATTERY;
                if (finish) scan_chan_next = CH_BATTERY;
            end
            default:
            begin
                mux_sel = MUX_MOTOR_ONE;
                if (finish) scan_chan_next = CH_MOTOR_ONE;
            end
        endcase
        if (finish)
        begin
            left_next = LEFT_RELOAD;
            sum_next  = '0;
        end
    end

    assign product    = avg_value_reg * avg_gain_reg;
    // saturate after dropping the eight fraction bits
    assign scaled_sat = (product[PROD_W-1:SCALED_W+8] != '0) ? SCALED_MAX
                                                             : product[SCALED_W+7:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_gain_reg <= CURRENT_GAIN_RESET;
            battery_gain_reg <= BATTERY_GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CURRENT_GAIN: current_gain_reg <= cfg_data;
                REG_BATTERY_GAIN: battery_gain_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_chan_reg <= CH_MOTOR_ONE;
            left_reg      <= LEFT_RELOAD;
            sum_reg       <= '0;
            avg_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                scan_chan_reg <= scan_chan_next;
                left_reg      <= left_next;
                sum_reg       <= sum_next;
            end
            // advance stage one when a finished channel arrives, else drain it once stage two is free
            if (accept && finish)
                avg_valid_reg <= 1'b1;
            else if (res_free)
                avg_valid_reg <= 1'b0;
            if (res_free)
                res_valid_reg <= avg_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && finish)
        begin
            avg_chan_reg  <= chan_eff;
            avg_value_reg <= avg_sat;
            avg_gain_reg  <= gain_sel;
            avg_mux_reg   <= mux_sel;
        end
        if (res_free && avg_valid_reg)
        begin
            res_chan_reg   <= avg_chan_reg;
            res_avg_reg    <= avg_value_reg;
            res_scaled_reg <= scaled_sat;
            res_mux_reg    <= avg_mux_reg;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {7'd0, res_mux_reg, res_scaled_reg, res_avg_reg, res_chan_reg};

endmodule
